// ===== rtl/plse_pkg.sv =====
// ----------------------------------------------------------------------------
// plse_pkg: shared types, constants and helpers for the polylogarithm unit
// Fixed-point constants, divisor width and power helpers, and term sign handling.
// ----------------------------------------------------------------------------
package plse_pkg;

    // Default number of series terms after the leading x term
    localparam int SERIES_TERMS      = 18;
    // Default number of series orders (orders two and up)
    localparam int MAX_SERIES_ORDERS = 6;
    // Odd terms used by the atanh expansion of ln(m)
    localparam int ATANH_TERMS       = 11;
    // Quotient bits retired per divider stage
    localparam int DIV_STEPS         = 4;
    // ln2 in Q.56
    localparam logic [63:0] LN2_Q56  = 64'h00B1_7217_F7D1_CF7A;

    // Control that travels with every beat
    typedef struct packed {
        logic [2:0] order;
        logic       last;
    } t_ctl;

    // n^s in 64-bit wrapping arithmetic (elaboration only)
    function automatic logic [63:0] pow_wrap(input int unsigned n, input int unsigned s);
        logic [63:0] r;
        r = 64'd1;
        for (int unsigned i = 0; i < s; i++) begin
            r = r * 64'(n);
        end
        return r;
    endfunction

    // Divisor width that covers every n^s and the odd atanh divisors
    function automatic int div_bits(input int nt, input int kmax);
        int          w;
        logic [63:0] p;
        w = 5;
        for (int n = 2; n <= nt + 1; n++) begin
            for (int s = 2; s <= kmax; s++) begin
                p = pow_wrap(n, s);
                for (int b = 0; b < 64; b++) begin
                    if (p[b] && (b + 1 > w)) begin
                        w = b + 1;
                    end
                end
            end
        end
        return w;
    endfunction

    // Signed contribution of one quotient to the accumulator
    function automatic logic [63:0] contrib(input logic [63:0] q, input logic neg,
                                            input logic li1);
        logic [63:0] r;
        if (li1) begin
            r = -(q << 1);
        end else if (neg) begin
            r = -q;
        end else begin
            r = q;
        end
        return r;
    endfunction

endpackage

// ===== rtl/polylogarithm_series_eval.sv =====
// ----------------------------------------------------------------------------
// polylogarithm_series_eval: Li_1 .. Li_K of a Q0.30 argument
// Pipeline: normalize, t divider, squaring and power chain, term dividers,
// adder stages, output. Results of one input follow on consecutive cycles
// while the receiver does not stall. Throughput: K result beats per input,
// one per cycle unless stalled; a new input is taken only as the sequencer issues
// the last order beat of the previous one. Reset (synchronous, active low)
// empties the pipeline and sets order_count to 7.
// ----------------------------------------------------------------------------
module polylogarithm_series_eval #(
    parameter int SERIES_TERMS      = plse_pkg::SERIES_TERMS,
    parameter int MAX_SERIES_ORDERS = plse_pkg::MAX_SERIES_ORDERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [30:0] i_x_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_order_index,
    output logic signed [31:0] o_li_value,
    output logic               o_last_result
);

    localparam int ATN   = plse_pkg::ATANH_TERMS;
    localparam int L     = (SERIES_TERMS > ATN) ? SERIES_TERMS : ATN;
    localparam int KMAX  = (MAX_SERIES_ORDERS + 1 > 7) ? 7 : MAX_SERIES_ORDERS + 1;
    localparam int DW    = plse_pkg::div_bits(SERIES_TERMS, KMAX);
    localparam int QW    = 64;
    localparam int STEPS = plse_pkg::DIV_STEPS;
    localparam int DSTG  = QW / STEPS;
    localparam int NSUM  = (L + 1) / 2;
    // global stage numbering
    localparam int I_TD  = 1;
    localparam int I_CH  = I_TD + DSTG + 1;
    localparam int I_LD  = I_CH + L;
    localparam int I_AC  = I_LD + DSTG + 1;
    localparam int I_OUT = I_AC + NSUM;
    localparam int D     = I_OUT + 1;

    // ------------------------------------------------------------------
    // configuration register
    logic [2:0] r_order_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_count <= 3'd7;
        end else if (i_cfg_we) begin
            r_order_count <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // pipeline movement: a stage loads when empty or when it drains forward
    logic            r_v   [D];
    plse_pkg::t_ctl  r_ctl [D];
    logic            w_mv  [D];

    always_comb begin
        w_mv[D-1] = !r_v[D-1] || !i_out_stall;
        for (int j = D - 2; j >= 0; j--) begin
            w_mv[j] = !r_v[j] || w_mv[j+1];
        end
    end

    // ------------------------------------------------------------------
    // sequencer: expands one input beat into K order beats
    logic               r_sq_busy;
    logic signed [30:0] r_sq_x;
    logic [2:0]         r_sq_ord;
    logic [2:0]         r_sq_k;
    logic               w_sq_last;
    logic               w_in_acc;
    logic [2:0]         w_eff_k;

    assign w_sq_last  = (r_sq_ord == r_sq_k);
    assign o_in_stall = r_sq_busy && !(w_mv[0] && w_sq_last);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_order_count == 3'd0) begin
            w_eff_k = 3'd1;
        end else if (r_order_count > 3'(KMAX)) begin
            w_eff_k = 3'(KMAX);
        end else begin
            w_eff_k = r_order_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_ord  <= 3'd1;
            r_sq_k    <= 3'd1;
        end else if (w_in_acc) begin
            r_sq_busy <= 1'b1;
            r_sq_ord  <= 3'd1;
            r_sq_k    <= w_eff_k;
        end else if (r_sq_busy && w_mv[0]) begin
            if (w_sq_last) begin
                r_sq_busy <= 1'b0;
            end else begin
                r_sq_ord <= r_sq_ord + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sq_x <= i_x_value;
        end
    end

    // valid bits and beat control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < D; j++) begin
                r_v[j] <= 1'b0;
            end
        end else begin
            if (w_mv[0]) begin
                r_v[0] <= r_sq_busy;
            end
            for (int j = 1; j < D; j++) begin
                if (w_mv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[0]) begin
            r_ctl[0] <= '{order: r_sq_ord, last: w_sq_last};
        end
        for (int j = 1; j < D; j++) begin
            if (w_mv[j]) begin
                r_ctl[j] <= r_ctl[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: u = 1 - x and its leading one
    logic signed [30:0] r_na_x;
    logic [31:0]        r_na_u;
    logic [4:0]         r_na_b;
    logic [31:0]        w_na_u;
    logic [4:0]         w_na_b;

    always_comb begin
        w_na_u = 32'h4000_0000 - 32'(r_sq_x);
        w_na_b = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (w_na_u[i]) begin
                w_na_b = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[0]) begin
            r_na_x <= r_sq_x;
            r_na_u <= w_na_u;
            r_na_b <= w_na_b;
        end
    end

    // ------------------------------------------------------------------
    // t = (m-1)/(m+1): setup then radix-2 long division
    logic signed [30:0] r_td_x   [DSTG+1];
    logic [4:0]         r_td_b   [DSTG+1];
    logic [31:0]        r_td_rem [DSTG+1];
    logic [QW-1:0]      r_td_nq  [DSTG+1];
    logic [31:0]        r_td_den [DSTG+1];
    logic [30:0]        w_td_m;
    logic [31:0]        w_td_den;
    logic [QW-1:0]      w_td_num;

    always_comb begin
        if (r_na_b <= 5'd30) begin
            w_td_m = 31'(r_na_u << (5'd30 - r_na_b));
        end else begin
            w_td_m = 31'(r_na_u >> 1);
        end
        w_td_den = {1'b0, w_td_m} + 32'h4000_0000;
        w_td_num = ({34'd0, w_td_m[29:0]} << 30) + 64'(w_td_den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[I_TD]) begin
            r_td_x[0]   <= r_na_x;
            r_td_b[0]   <= r_na_b;
            r_td_rem[0] <= '0;
            r_td_nq[0]  <= w_td_num;
            r_td_den[0] <= w_td_den;
        end
    end

    for (genvar k = 1; k <= DSTG; k++) begin : g_td
        logic [31:0]   w_rem;
        logic [QW-1:0] w_nq;

        always_comb begin : p_step
            logic [32:0] tt;
            logic        ge;
            w_rem = r_td_rem[k-1];
            w_nq  = r_td_nq[k-1];
            for (int st = 0; st < STEPS; st++) begin
                tt = {w_rem, w_nq[QW-1]};
                ge = (tt >= {1'b0, r_td_den[k-1]});
                if (ge) begin
                    w_rem = 32'(tt - {1'b0, r_td_den[k-1]});
                end else begin
                    w_rem = tt[31:0];
                end
                w_nq = {w_nq[QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_mv[I_TD+k]) begin
                r_td_x[k]   <= r_td_x[k-1];
                r_td_b[k]   <= r_td_b[k-1];
                r_td_rem[k] <= w_rem;
                r_td_nq[k]  <= w_nq;
                r_td_den[k] <= r_td_den[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // squaring stage and power chain c[j] = round(c[j-1] * m)
    logic signed [63:0] r_ch_acc [L];
    logic signed [31:0] r_ch_m   [L];
    logic signed [31:0] r_ch_c   [L][L];
    logic signed [31:0] w_sq_a;
    logic signed [63:0] w_sq_p;
    logic signed [31:0] w_sq_v;
    logic signed [31:0] w_sq_xs;
    logic signed [6:0]  w_sq_e;
    logic signed [63:0] w_sq_acc;
    logic               w_sq_li1;

    always_comb begin
        w_sq_li1 = (r_ctl[I_CH-1].order == 3'd1);
        w_sq_xs  = 32'(r_td_x[DSTG]);
        w_sq_a   = w_sq_li1 ? $signed({2'b00, r_td_nq[DSTG][29:0]}) : w_sq_xs;
        w_sq_p   = w_sq_a * w_sq_a;
        w_sq_v   = 32'((w_sq_p + 64'sd536870912) >>> 30);
        w_sq_e   = 7'sd30 - $signed({2'b00, r_td_b[DSTG]});
        if (w_sq_li1) begin
            w_sq_acc = $signed(plse_pkg::LN2_Q56) * 64'(w_sq_e);
        end else begin
            w_sq_acc = $signed({{3{r_td_x[DSTG][30]}}, r_td_x[DSTG], 30'd0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[I_CH]) begin
            r_ch_acc[0]  <= w_sq_acc;
            r_ch_m[0]    <= w_sq_li1 ? w_sq_v : w_sq_xs;
            r_ch_c[0][0] <= w_sq_li1 ? w_sq_a : w_sq_v;
        end
    end

    for (genvar j = 1; j < L; j++) begin : g_ch
        logic signed [63:0] w_p;
        assign w_p = r_ch_c[j-1][j-1] * r_ch_m[j-1];

        always_ff @(posedge i_clk) begin
            if (w_mv[I_CH+j]) begin
                r_ch_acc[j] <= r_ch_acc[j-1];
                r_ch_m[j]   <= r_ch_m[j-1];
                for (int i = 0; i < j; i++) begin
                    r_ch_c[j][i] <= r_ch_c[j-1][i];
                end
                r_ch_c[j][j] <= 32'((w_p + 64'sd536870912) >>> 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // per-lane term division: setup then radix-2 long division
    logic signed [63:0] r_ld_acc [DSTG+1];
    logic [DW-1:0]      r_ld_rem [DSTG+1][L];
    logic [QW-1:0]      r_ld_nq  [DSTG+1][L];
    logic [DW-1:0]      r_ld_d   [DSTG+1][L];
    logic               r_ld_neg [DSTG+1][L];
    logic [DW-1:0]      w_dtab   [L][8];

    always_ff @(posedge i_clk) begin
        if (w_mv[I_LD]) begin
            r_ld_acc[0] <= r_ch_acc[L-1];
        end
    end

    for (genvar i = 0; i < L; i++) begin : g_lane
        logic [DW-1:0] w_d;
        logic [QW-1:0] w_n;
        logic          w_neg;
        logic [31:0]   w_mag;
        logic [2:0]    w_ord;

        assign w_dtab[i][0] = DW'(1);
        assign w_dtab[i][1] = DW'(1);
        for (genvar ss = 2; ss < 8; ss++) begin : g_tab
            assign w_dtab[i][ss] = DW'(plse_pkg::pow_wrap(i + 2, ss));
        end

        // divisor and rounded numerator of this lane's term
        always_comb begin
            w_ord = r_ctl[I_LD-1].order;
            w_mag = r_ch_c[L-1][i][31] ? 32'(-r_ch_c[L-1][i]) : 32'(r_ch_c[L-1][i]);
            w_d   = DW'(1);
            w_n   = '0;
            w_neg = 1'b0;
            if (w_ord == 3'd1) begin
                if (i < ATN) begin
                    w_d = DW'(2 * i + 1);
                    w_n = ({32'd0, r_ch_c[L-1][i]} << 26) + 64'(w_d >> 1);
                end
            end else if (i < SERIES_TERMS) begin
                w_d   = w_dtab[i][w_ord];
                w_n   = ({32'd0, w_mag} << 30) + 64'(w_d >> 1);
                w_neg = r_ch_c[L-1][i][31];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_mv[I_LD]) begin
                r_ld_rem[0][i] <= '0;
                r_ld_nq[0][i]  <= w_n;
                r_ld_d[0][i]   <= w_d;
                r_ld_neg[0][i] <= w_neg;
            end
        end

        for (genvar k = 1; k <= DSTG; k++) begin : g_st
            logic [DW-1:0] w_rem;
            logic [QW-1:0] w_nq;

            always_comb begin : p_step
                logic [DW:0] tt;
                logic        ge;
                w_rem = r_ld_rem[k-1][i];
                w_nq  = r_ld_nq[k-1][i];
                for (int st = 0; st < STEPS; st++) begin
                    tt = {w_rem, w_nq[QW-1]};
                    ge = (tt >= {1'b0, r_ld_d[k-1][i]});
                    if (ge) begin
                        w_rem = DW'(tt - {1'b0, r_ld_d[k-1][i]});
                    end else begin
                        w_rem = tt[DW-1:0];
                    end
                    w_nq = {w_nq[QW-2:0], ge};
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_mv[I_LD+k]) begin
                    r_ld_rem[k][i] <= w_rem;
                    r_ld_nq[k][i]  <= w_nq;
                    r_ld_d[k][i]   <= r_ld_d[k-1][i];
                    r_ld_neg[k][i] <= r_ld_neg[k-1][i];
                end
            end
        end
    end

    for (genvar k = 1; k <= DSTG; k++) begin : g_ldacc
        always_ff @(posedge i_clk) begin
            if (w_mv[I_LD+k]) begin
                r_ld_acc[k] <= r_ld_acc[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // accumulate two lane terms per stage
    logic signed [63:0] r_ac_acc [NSUM];
    logic [QW-1:0]      r_ac_q   [NSUM][L];
    logic               r_ac_neg [NSUM][L];
    logic signed [63:0] a_acc    [NSUM+1];
    logic [QW-1:0]      a_q      [NSUM+1][L];
    logic               a_neg    [NSUM+1][L];

    assign a_acc[0] = r_ld_acc[DSTG];
    for (genvar i = 0; i < L; i++) begin : g_a0
        assign a_q[0][i]   = r_ld_nq[DSTG][i];
        assign a_neg[0][i] = r_ld_neg[DSTG][i];
    end

    for (genvar g = 0; g < NSUM; g++) begin : g_ac
        logic               w_li1;
        logic signed [63:0] w_sum;

        assign w_li1 = (r_ctl[I_AC+g-1].order == 3'd1);

        if (2 * g + 1 < L) begin : g_two
            assign w_sum = a_acc[g]
                + $signed(plse_pkg::contrib(a_q[g][2*g], a_neg[g][2*g], w_li1))
                + $signed(plse_pkg::contrib(a_q[g][2*g+1], a_neg[g][2*g+1], w_li1));
        end else begin : g_one
            assign w_sum = a_acc[g]
                + $signed(plse_pkg::contrib(a_q[g][2*g], a_neg[g][2*g], w_li1));
        end

        always_ff @(posedge i_clk) begin
            if (w_mv[I_AC+g]) begin
                r_ac_acc[g] <= w_sum;
                for (int i = 0; i < L; i++) begin
                    r_ac_q[g][i]   <= a_q[g][i];
                    r_ac_neg[g][i] <= a_neg[g][i];
                end
            end
        end

        assign a_acc[g+1] = r_ac_acc[g];
        for (genvar i = 0; i < L; i++) begin : g_an
            assign a_q[g+1][i]   = r_ac_q[g][i];
            assign a_neg[g+1][i] = r_ac_neg[g][i];
        end
    end

    // ------------------------------------------------------------------
    // output stage: round to Q7.24
    logic signed [31:0] r_o_value;
    logic signed [63:0] w_o_rnd;

    always_comb begin
        if (r_ctl[I_OUT-1].order == 3'd1) begin
            w_o_rnd = (a_acc[NSUM] + 64'sd2147483648) >>> 32;
        end else begin
            w_o_rnd = (a_acc[NSUM] + 64'sd34359738368) >>> 36;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[I_OUT]) begin
            r_o_value <= w_o_rnd[31:0];
        end
    end

    assign o_out_valid   = r_v[I_OUT];
    assign o_order_index = r_ctl[I_OUT].order;
    assign o_last_result = r_ctl[I_OUT].last;
    assign o_li_value    = r_o_value;

    // ------------------------------------------------------------------
    // assertions
    a_seq_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_busy |-> (r_sq_ord != 3'd0) && (r_sq_ord <= r_sq_k))
        else $error("sequencer order out of range");

    a_seq_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_sq_busy && (r_sq_ord == 3'd1))
        else $error("accepted input did not start at order one");

    a_out_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_order_index != 3'd0)
                        && (o_last_result || (o_order_index < 3'(KMAX))))
        else $error("result beat carries a bad order");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_busy |-> (r_sq_k != 3'd0) && (r_sq_k <= 3'(KMAX)))
        else $error("order count latched out of range");

endmodule

// ===== test/plse_checker.sv =====
// ----------------------------------------------------------------------------
// plse_checker: result predictor and scoreboard for polylogarithm_series_eval
// Watches the register port and both channels, predicts Li_1 .. Li_K for each
// accepted argument and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module plse_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [30:0] i_x_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_order_index,
    input  logic signed [31:0] i_li_value,
    input  logic               i_last_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [2:0]         order;
        logic signed [31:0] value;
        logic               last;
    } t_li_beat;

    t_li_beat   li_queue[$];
    logic [2:0] orders_reg;

    // Floor of v / 2^sh after adding half
    function automatic longint rnd_shift(input longint v, input int sh);
        longint r;
        r = (v + (longint'(1) << (sh - 1))) >>> sh;
        return r;
    endfunction

    // -ln(1-x) in Q7.24
    function automatic longint calc_li1(input longint x);
        longint unsigned u, m, num, den, t, t2, p, d, sum;
        longint          r;
        int              b;
        u   = longint'(1 << 30) - x;
        b   = 0;
        sum = 0;
        while (b < 63 && (u >> (b + 1)) != 0) b++;
        m   = (b <= 30) ? (u << (30 - b)) : (u >> (b - 30));
        num = m - (64'd1 << 30);
        den = m + (64'd1 << 30);
        t   = ((num << 30) + den / 2) / den;
        t2  = (t * t + (64'd1 << 29)) >> 30;
        p   = t;
        for (int k = 0; k < plse_pkg::ATANH_TERMS; k++) begin
            d   = 2 * k + 1;
            sum += ((p << 26) + d / 2) / d;
            p   = (p * t2 + (64'd1 << 29)) >> 30;
        end
        r = longint'(30 - b) * longint'(plse_pkg::LN2_Q56) - longint'(2 * sum);
        return rnd_shift(r, 32);
    endfunction

    // Truncated series for order s >= 2, in Q7.24
    function automatic longint calc_series(
        input longint pw[plse_pkg::SERIES_TERMS + 2], input int s);
        longint          acc, p;
        longint unsigned d, mag, q;
        acc = pw[1] * (longint'(1) << 30);
        for (int n = 2; n <= plse_pkg::SERIES_TERMS + 1; n++) begin
            d = 1;
            for (int i = 0; i < s; i++) d = d * n;
            p   = pw[n];
            mag = (p < 0) ? longint'(-p) : p;
            q   = ((mag << 30) + d / 2) / d;
            acc += (p < 0) ? -longint'(q) : longint'(q);
        end
        return rnd_shift(acc, 36);
    endfunction

    // Push the predicted beats for one argument
    task automatic predict_orders(input logic signed [30:0] xin);
        longint   pw[plse_pkg::SERIES_TERMS + 2];
        longint   x;
        int       k;
        t_li_beat bt;
        x = longint'(xin);
        k = (orders_reg == 0) ? 1 : int'(orders_reg);
        if (k > 1 + plse_pkg::MAX_SERIES_ORDERS) k = 1 + plse_pkg::MAX_SERIES_ORDERS;
        pw[0] = longint'(1) << 30;
        pw[1] = x;
        for (int n = 2; n <= plse_pkg::SERIES_TERMS + 1; n++)
            pw[n] = rnd_shift(pw[n - 1] * x, 30);
        for (int s = 1; s <= k; s++) begin
            bt.order = s[2:0];
            bt.value = 32'((s == 1) ? calc_li1(x) : calc_series(pw, s));
            bt.last  = (s == k);
            li_queue.push_back(bt);
        end
    endtask

    always @(posedge i_clk) begin
        t_li_beat exp_b;
        if (!i_rst_n) begin
            orders_reg = 3'd7;
            li_queue.delete();
            o_fail_count = 0;
        end else begin
            // input beat
            if (i_in_valid && !i_in_stall) predict_orders(i_x_value);
            // result beat
            if (i_out_valid && !i_out_stall) begin
                if (li_queue.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected beat: order %0d value %0d last %0b",
                                 i_order_index, i_li_value, i_last_result);
                end else begin
                    exp_b = li_queue.pop_front();
                    if (exp_b.order !== i_order_index || exp_b.value !== i_li_value ||
                        exp_b.last !== i_last_result) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp order %0d value %0d last %0b, %s",
                                     exp_b.order, exp_b.value, exp_b.last,
                                     $sformatf("got %0d %0d %0b", i_order_index,
                                               i_li_value, i_last_result));
                    end
                end
            end
            if (i_cfg_we) orders_reg = i_cfg_data;
        end
        o_pending = li_queue.size();
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for polylogarithm_series_eval
// Drives directed and random arguments in bursts across several order counts,
// with random and long receiver stalls; plse_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY_WAIT = 120;
    localparam int WATCH_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [30:0] i_x_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_order_index;
    logic signed [31:0] o_li_value;
    logic               o_last_result;
    int                 fail_count;
    int                 pending;
    logic               hold_req;
    int                 idle_cycles;

    polylogarithm_series_eval dut (.*);

    plse_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_in_valid,
        .i_in_stall(o_in_stall), .i_x_value, .i_out_valid(o_out_valid), .i_out_stall,
        .i_order_index(o_order_index), .i_li_value(o_li_value),
        .i_last_result(o_last_result), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall pattern that changes mode, plus one long hold-off
    initial begin
        int   mode;
        logic hold_done;
        i_out_stall = 1'b0;
        mode = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Watchdog: cycles with no beat on either channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Send one argument beat; returns at the accepting edge
    task automatic send_arg(input logic signed [30:0] x);
        i_in_valid <= 1'b1;
        i_x_value  <= x;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid for a random gap after some beats
    task automatic maybe_gap();
        if ($urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Wait for all results, let the pipeline drain, then set the order count
    task automatic set_orders(input logic [2:0] k);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic signed [30:0] rand_arg();
        logic [30:0] r;
        r = 31'($urandom);
        case ($urandom_range(0, 3))
            0: r = r >>> $urandom_range(0, 29);
            1: r = {r[30], 30'h3FFF_FFF0 | r[3:0]};
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        logic [2:0]         orders[7];
        logic signed [30:0] directed[20];
        orders = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd2, 3'd7};
        directed = '{
            31'sh0, 31'sh4000_0000, 31'sh3FFF_FFFF, 31'sh1, 31'sh7FFF_FFFF,
            31'sh2000_0000, 31'sh6000_0000, 31'sh3FFF_FFFE, 31'sh3FFF_0000,
            31'sh4000_0001, 31'sh1000_0000, 31'sh7000_0000, 31'sh3000_0000,
            31'sh5555_5555, 31'sh2AAA_AAAA, 31'sh0000_8000, 31'sh7FFF_8000,
            31'sh3C00_0000, 31'sh2, 31'sh7FFF_FFFE};
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 3'd0;
        i_in_valid = 1'b0;
        i_x_value  = '0;
        hold_req   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed arguments at the reset order count
        foreach (directed[i]) begin
            send_arg(directed[i]);
            maybe_gap();
        end

        // random phases across order counts
        foreach (orders[p]) begin
            set_orders(orders[p]);
            for (int i = 0; i < 52; i++) begin
                if (p == 3 && i == 5) hold_req <= 1'b1;
                send_arg(rand_arg());
                maybe_gap();
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
